### rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the subarray sum target counter
// Sizes, the hash multiplier, the queue word and the back end states.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned MAX_ITEMS   = 4096;
  // must be a power of two: home slot and probe step wrap on the address bits
  localparam int unsigned TABLE_SLOTS = 8192;
  localparam int unsigned TABLE_BITS  = $clog2(TABLE_SLOTS);
  localparam int unsigned ITEM_W      = $clog2(MAX_ITEMS + 1);

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned MATCH_W = 24;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned EPOCH_W = 8;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [SUM_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  // one table slot: epoch tag (zero marks never used), key, occurrence count
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [SUM_W-1:0]   key;
    logic [CNT_W-1:0]   count;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // word passed from the front end to the back end
  typedef struct packed {
    logic [SUM_W-1:0] prefix;
    logic             skip;
    logic             last;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_SEED,
    ST_IDLE,
    ST_HASH1,
    ST_HASH2,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } back_state_e;

endpackage

### rtl/subarray_sum_target_counter_top.sv
// ----------------------------------------------------------------------------
// subarray_sum_target_counter_top: counts contiguous runs summing to a target
//
//   channel   valid         stall         payload
//   input     in_valid_i    in_stall_o    value_i, last_i
//   result    out_valid_o   out_stall_i   running_count_o, overflow_o, is_last_o
//   config    cfg_we_i      -             cfg_wdata_i (target_sum)
//
// In the back end an element goes through: queue pop, then two probes
// (lookup, bump) of hash, hash, read, compare on the one table RAM, then result.
// Each extra slot on a linear probe chain adds a read and compare; an element
// past the limit skips to the result. After reset and every 255th last word the
// input stalls for a clearing pass over all TABLE_SLOTS slots, then a seed write.
// A stalled result holds; the queue keeps taking words until it fills.
// ----------------------------------------------------------------------------
module subarray_sum_target_counter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ssc_pkg::VALUE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ssc_pkg::VALUE_W-1:0] value_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ssc_pkg::MATCH_W-1:0] running_count_o,
  output logic                        overflow_o,
  output logic                        is_last_o
);
  import ssc_pkg::*;

  logic [VALUE_W-1:0] target_q;
  logic               push;
  work_t              push_data;
  logic               pop;
  work_t              pop_data;
  fifo_status_t       fifo_status;
  logic               clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  ssc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .value_i       (value_i),
    .last_i        (last_i),
    .in_stall_o    (in_stall_o),
    .fifo_status_i (fifo_status),
    .clearing_i    (clearing),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ssc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  ssc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .target_i        (target_q),
    .fifo_status_i   (fifo_status),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .running_count_o (running_count_o),
    .overflow_o      (overflow_o),
    .is_last_o       (is_last_o)
  );

endmodule

### rtl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ssc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ssc_fifo.sv
// ----------------------------------------------------------------------------
// ssc_fifo: short queue between front end and back end
// Holds prepared words so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ssc_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ssc_pkg::work_t       push_data_i,
  input  logic                 pop_i,
  output ssc_pkg::work_t       pop_data_o,
  output ssc_pkg::fifo_status_t status_o
);
  import ssc_pkg::*;

  work_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

### rtl/ssc_front.sv
// ----------------------------------------------------------------------------
// ssc_front: input acceptance and prefix tracking
// Keeps the prefix sum and element count, flags elements past the limit.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [ssc_pkg::VALUE_W-1:0]   value_i,
  input  logic                          last_i,
  output logic                          in_stall_o,
  input  ssc_pkg::fifo_status_t         fifo_status_i,
  input  logic                          clearing_i,
  output logic                          push_o,
  output ssc_pkg::work_t                push_data_o
);
  import ssc_pkg::*;

  logic [SUM_W-1:0]  prefix_q, prefix_d;
  logic [ITEM_W-1:0] items_q, items_d;
  logic [SUM_W-1:0]  prefix_sum;
  logic              limit;
  logic              accept;

  assign in_stall_o = fifo_status_i.full | clearing_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign limit      = (items_q >= ITEM_W'(MAX_ITEMS));
  assign prefix_sum = prefix_q + {{(SUM_W - VALUE_W){value_i[VALUE_W-1]}}, value_i};

  always_comb begin
    prefix_d = prefix_q;
    items_d  = items_q;
    if (accept) begin
      if (last_i) begin
        prefix_d = '0;
        items_d  = '0;
      end else if (!limit) begin
        prefix_d = prefix_sum;
        items_d  = items_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= '0;
      items_q  <= '0;
    end else begin
      prefix_q <= prefix_d;
      items_q  <= items_d;
    end
  end

  assign push_o             = accept;
  assign push_data_o.prefix = limit ? prefix_q : prefix_sum;
  assign push_data_o.skip   = limit;
  assign push_data_o.last   = last_i;

endmodule

### rtl/ssc_back.sv
// ----------------------------------------------------------------------------
// ssc_back: hash table sequencer
// Looks up prefix minus target, then bumps the prefix, one probe at a time.
// ----------------------------------------------------------------------------
module ssc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ssc_pkg::VALUE_W-1:0]   target_i,
  input  ssc_pkg::fifo_status_t         fifo_status_i,
  input  ssc_pkg::work_t                pop_data_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssc_pkg::MATCH_W-1:0]   running_count_o,
  output logic                          overflow_o,
  output logic                          is_last_o
);
  import ssc_pkg::*;

  localparam int unsigned TB = TABLE_BITS;

  back_state_e        state_q, state_d;
  logic [SUM_W-1:0]   key_q, key_d;
  logic [SUM_W-1:0]   keyb_q, keyb_d;
  logic               phase_q, phase_d;
  logic               last_q, last_d;
  logic [MATCH_W-1:0] match_q, match_d;
  logic               ovf_q, ovf_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [TB-1:0]      addr_q, addr_d;
  logic [TB-1:0]      probe_q, probe_d;
  logic [SUM_W-1:0]   prod_q, prod_d;
  logic [TB-1:0]      cross_q, cross_d;

  logic               out_valid_q, out_valid_d;
  logic [MATCH_W-1:0] out_count_q;
  logic               out_ovf_q;
  logic               out_last_q;

  logic               ram_we;
  logic [TB-1:0]      ram_waddr;
  slot_t              ram_wdata;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_t              rd_slot;

  logic               slot_used;
  logic               key_hit;
  logic               chain_end;
  logic               out_load;
  logic               epoch_wrap;
  logic               clear_done;
  logic [MATCH_W:0]   match_sum;
  logic [2*TB-1:0]    cross_a, cross_b;

  ssc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_slot    = slot_t'(ram_rdata);
  assign slot_used  = (rd_slot.epoch == epoch_q);
  assign key_hit    = slot_used && (rd_slot.key == key_q);
  assign chain_end  = (probe_q == TB'(TABLE_SLOTS - 1));
  assign out_load   = ~out_valid_q | ~out_stall_i;
  assign epoch_wrap = (epoch_q == '1);
  assign clear_done = (addr_q == TB'(TABLE_SLOTS - 1));
  assign match_sum  = {1'b0, match_q} + (MATCH_W + 1)'(rd_slot.count);

  // home slot: bits [32+TB-1:32] of key * HASH_MULT, built from 32-bit halves
  assign cross_a = key_q[TB-1:0] * HASH_MULT[32 +: TB];
  assign cross_b = key_q[32 +: TB] * HASH_MULT[TB-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clear_done) state_d = ST_SEED;
      end
      ST_SEED:  state_d = ST_IDLE;
      ST_IDLE: begin
        if (!fifo_status_i.empty) begin
          state_d = pop_data_i.skip ? ST_EMIT : ST_HASH1;
        end
      end
      ST_HASH1: state_d = ST_HASH2;
      ST_HASH2: state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP: begin
        if (slot_used && !key_hit && !chain_end) begin
          state_d = ST_READ;
        end else begin
          state_d = phase_q ? ST_EMIT : ST_HASH1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          if (!last_q)        state_d = ST_IDLE;
          else if (epoch_wrap) state_d = ST_CLEAR;
          else                 state_d = ST_SEED;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and table port
  always_comb begin
    key_d       = key_q;
    keyb_d      = keyb_q;
    phase_d     = phase_q;
    last_d      = last_q;
    match_d     = match_q;
    ovf_d       = ovf_q;
    epoch_d     = epoch_q;
    addr_d      = addr_q;
    probe_d     = probe_q;
    prod_d      = prod_q;
    cross_d     = cross_q;
    out_valid_d = out_valid_q & out_stall_i;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
      end
      ST_SEED: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.epoch = epoch_q;
        ram_wdata.key   = '0;
        ram_wdata.count = CNT_W'(1);
      end
      ST_IDLE: begin
        if (!fifo_status_i.empty) begin
          pop_o   = 1'b1;
          key_d   = pop_data_i.prefix
                    - {{(SUM_W - VALUE_W){target_i[VALUE_W-1]}}, target_i};
          keyb_d  = pop_data_i.prefix;
          last_d  = pop_data_i.last;
          phase_d = 1'b0;
          if (pop_data_i.skip) ovf_d = 1'b1;
        end
      end
      ST_HASH1: begin
        prod_d  = SUM_W'(key_q[31:0]) * SUM_W'(HASH_MULT[31:0]);
        cross_d = cross_a[TB-1:0] + cross_b[TB-1:0];
      end
      ST_HASH2: begin
        addr_d  = prod_q[32 +: TB] + cross_q;
        probe_d = '0;
      end
      ST_READ: begin
      end
      ST_CMP: begin
        if (slot_used && !key_hit && !chain_end) begin
          // advance along the probe chain
          addr_d  = addr_q + 1'b1;
          probe_d = probe_q + 1'b1;
        end else if (!phase_q) begin
          if (key_hit) begin
            match_d = match_sum[MATCH_W] ? '1 : match_sum[MATCH_W-1:0];
          end
          key_d   = keyb_q;
          phase_d = 1'b1;
        end else if (key_hit) begin
          ram_we          = 1'b1;
          ram_wdata       = rd_slot;
          ram_wdata.count = (rd_slot.count == '1) ? rd_slot.count : rd_slot.count + 1'b1;
        end else if (!slot_used) begin
          ram_we          = 1'b1;
          ram_wdata.epoch = epoch_q;
          ram_wdata.key   = key_q;
          ram_wdata.count = CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (last_q) begin
            match_d = '0;
            ovf_d   = 1'b0;
            addr_d  = '0;
            // old slots go stale with the epoch; sweep only when it wraps
            epoch_d = epoch_wrap ? EPOCH_W'(1) : epoch_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      match_q     <= '0;
      ovf_q       <= 1'b0;
      epoch_q     <= EPOCH_W'(1);
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      match_q     <= match_d;
      ovf_q       <= ovf_d;
      epoch_q     <= epoch_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    keyb_q  <= keyb_d;
    phase_q <= phase_d;
    last_q  <= last_d;
    probe_q <= probe_d;
    prod_q  <= prod_d;
    cross_q <= cross_d;
    if (state_q == ST_EMIT && out_load) begin
      out_count_q <= match_q;
      out_ovf_q   <= ovf_q;
      out_last_q  <= last_q;
    end
  end

  assign clearing_o      = (state_q == ST_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign running_count_o = out_count_q;
  assign overflow_o      = out_ovf_q;
  assign is_last_o       = out_last_q;

`ifndef ASSERT_OFF
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == ST_IDLE)
    else $error("queue popped outside idle");

  a_clear_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> ram_we)
    else $error("clearing pass skipped a slot");

  a_lookup_readonly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && !phase_q) |-> !ram_we)
    else $error("lookup phase wrote the table");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_load && last_q) |=> (match_q == '0 && !ovf_q))
    else $error("sequence totals not cleared after last word");
`endif

endmodule
